### rtl/huffman_tree_decoder_assert.svh
// assertion macros shared by the huffman tree decoder rtl
// no dependencies; included by files that carry concurrent checks
`ifndef HUFFMAN_TREE_DECODER_ASSERT_SVH
`define HUFFMAN_TREE_DECODER_ASSERT_SVH

// same-cycle implication under asynchronous active-low reset
`define HTD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under asynchronous active-low reset
`define HTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/htd_pkg.sv
// shared constants and codes for the huffman tree decoder
// no dependencies; imported by huffman_tree_decoder, its checker and its testbench
`default_nettype none

package htd_pkg;

    // default sizing
    localparam int DEF_MAX_SYMBOLS  = 256;
    localparam int DEF_MAX_CODE_LEN = 32;

    // fixed field widths
    localparam int FUNC_W   = 2;
    localparam int SYM_W    = 8;
    localparam int LEN_W    = 8;
    localparam int CODE_W   = 32;
    localparam int STATUS_W = 3;

    // packed input transfer: symbol, code_len, code, bit_req, padded to bytes
    localparam int IN_DATA_W  = 56;
    // packed output transfer: symbol_out
    localparam int OUT_DATA_W = 8;

    // operation selector
    typedef enum logic [FUNC_W-1:0] {
        FN_LOAD   = 2'd0,
        FN_DECODE = 2'd1,
        FN_CLEAR  = 2'd2
    } func_t;

    // result status
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_MISSING  = 3'd1,
        ST_BADLEN   = 3'd2,
        ST_CONFLICT = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

endpackage

`default_nettype wire

### rtl/htd_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies; holds the huffman node store
`default_nettype none

module htd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/huffman_tree_decoder.sv
// huffman tree decoder: decode follows one branch, then tests the reached node; a missing
// branch or a leaf loads the output register, an internal node gives no result; a held
// output stalls it. load runs a check walk, a room check, then a commit walk, one node
// per cycle on the node ram, and writes the leaf; clear and unused codes give no result
// reset empties the tree at once: nodes at or above the fill count read as empty,
// so no clearing pass runs; output valid drops on reset
`default_nettype none
`include "huffman_tree_decoder_assert.svh"

module huffman_tree_decoder #(
    parameter int MAX_SYMBOLS  = htd_pkg::DEF_MAX_SYMBOLS,
    parameter int MAX_CODE_LEN = htd_pkg::DEF_MAX_CODE_LEN
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // symbol[7:0], code_len[15:8], code[47:16], bit_req[48], zero pad
    input  wire logic [htd_pkg::IN_DATA_W-1:0] s_tdata,
    // func[1:0]
    input  wire logic [htd_pkg::FUNC_W-1:0]    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // symbol_out[7:0]
    output logic [htd_pkg::OUT_DATA_W-1:0]     m_tdata,
    // status[2:0]
    output logic [htd_pkg::STATUS_W-1:0]       m_tuser
);

    import htd_pkg::*;

    localparam int NODE_CAP = 2 * MAX_SYMBOLS;
    localparam int NW       = $clog2(NODE_CAP);
    localparam int CW       = $clog2(NODE_CAP + 1);
    localparam int LW       = $clog2(MAX_CODE_LEN);
    localparam int SW       = ((CW > LEN_W) ? CW : LEN_W) + 1;
    localparam int EW       = 2 * NW + 1 + SYM_W;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             leaf;
        logic [NW-1:0]    right;
        logic [NW-1:0]    left;
    } node_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK,
        S_FULL,
        S_CMT,
        S_LEAF,
        S_DSTEP,
        S_DLEAF,
        S_RESP
    } state_t;

    // node entry with one branch replaced
    function automatic node_t set_link(node_t e, logic b, logic [NW-1:0] c);
        node_t r;
        r = e;
        if (b)
        begin
            r.right = c;
        end
        else
        begin
            r.left = c;
        end
        return r;
    endfunction

    state_t               state_reg,        state_next;
    logic [NW-1:0]        root_left_reg,    root_left_next;
    logic [NW-1:0]        root_right_reg,   root_right_next;
    logic [CW-1:0]        nodes_used_reg,   nodes_used_next;
    logic [NW-1:0]        current_node_reg, current_node_next;
    logic [NW-1:0]        cur_reg,          cur_next;
    logic [LW-1:0]        idx_reg,          idx_next;
    logic [LEN_W-1:0]     need_reg,         need_next;
    logic [SYM_W-1:0]     sym_reg,          sym_next;
    logic [LEN_W-1:0]     len_reg,          len_next;
    logic [CODE_W-1:0]    code_reg,         code_next;
    logic                 bit_reg,          bit_next;
    logic                 fetch_root_reg,   fetch_root_next;
    logic                 fetch_valid_reg,  fetch_valid_next;
    status_t              st_reg,           st_next;
    logic [SYM_W-1:0]     osym_reg,         osym_next;
    logic                 m_tvalid_reg,     m_tvalid_next;
    logic [STATUS_W-1:0]  m_tuser_reg,      m_tuser_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg,     m_tdata_next;

    logic                 ram_we;
    logic [NW-1:0]        ram_waddr;
    logic [EW-1:0]        ram_wdata;
    logic [NW-1:0]        ram_raddr;
    logic [EW-1:0]        ram_rdata;

    node_t                ent;
    node_t                wr_node;
    logic                 wr_cur;
    logic                 fetch_en;
    logic [NW-1:0]        fetch_addr;
    logic [6:0]           idx_ext;
    logic                 code_b;
    logic                 last_step;
    logic [NW-1:0]        child;
    logic [SW-1:0]        fill_sum;

    // node store
    htd_ram #(
        .WIDTH (EW),
        .DEPTH (NODE_CAP)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // fetched node: root from flops, unallocated nodes read empty
    always_comb
    begin
        if (fetch_root_reg)
        begin
            ent = '{sym: '0, leaf: 1'b0, right: root_right_reg, left: root_left_reg};
        end
        else if (fetch_valid_reg)
        begin
            ent = node_t'(ram_rdata);
        end
        else
        begin
            ent = '0;
        end
    end

    // walk step decode
    always_comb
    begin
        idx_ext   = 7'(idx_reg);
        code_b    = (idx_ext < 7'(CODE_W)) ? code_reg[idx_ext[4:0]] : 1'b0;
        last_step = (len_reg == (LEN_W'(idx_reg) + LEN_W'(1)));
        child     = (state_reg == S_DSTEP) ? (bit_reg ? ent.right : ent.left)
                                           : (code_b ? ent.right : ent.left);
        fill_sum  = SW'(nodes_used_reg) + SW'(need_reg);
    end

    // sequencer next state
    always_comb
    begin
        state_next        = state_reg;
        root_left_next    = root_left_reg;
        root_right_next   = root_right_reg;
        nodes_used_next   = nodes_used_reg;
        current_node_next = current_node_reg;
        cur_next          = cur_reg;
        idx_next          = idx_reg;
        need_next         = need_reg;
        sym_next          = sym_reg;
        len_next          = len_reg;
        code_next         = code_reg;
        bit_next          = bit_reg;
        st_next           = st_reg;
        osym_next         = osym_reg;
        m_tvalid_next     = m_tvalid_reg;
        m_tuser_next      = m_tuser_reg;
        m_tdata_next      = m_tdata_reg;
        s_tready          = 1'b0;
        fetch_en          = 1'b0;
        fetch_addr        = cur_reg;
        wr_cur            = 1'b0;
        wr_node           = '0;
        ram_we            = 1'b0;
        ram_waddr         = cur_reg;
        ram_wdata         = '0;

        // output register drains
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    sym_next  = s_tdata[7:0];
                    len_next  = s_tdata[15:8];
                    code_next = s_tdata[47:16];
                    bit_next  = s_tdata[48];
                    case (func_t'(s_tuser))
                        FN_LOAD:
                        begin
                            if (s_tdata[15:8] == '0 ||
                                s_tdata[15:8] > LEN_W'(MAX_CODE_LEN))
                            begin
                                st_next    = ST_BADLEN;
                                osym_next  = '0;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                cur_next   = '0;
                                idx_next   = '0;
                                fetch_en   = 1'b1;
                                fetch_addr = '0;
                                state_next = S_CHK;
                            end
                        end
                        FN_DECODE:
                        begin
                            fetch_en   = 1'b1;
                            fetch_addr = current_node_reg;
                            state_next = S_DSTEP;
                        end
                        FN_CLEAR:
                        begin
                            root_left_next    = '0;
                            root_right_next   = '0;
                            nodes_used_next   = CW'(1);
                            current_node_next = '0;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // check walk over the existing path
            S_CHK:
            begin
                if (ent.leaf)
                begin
                    st_next    = ST_CONFLICT;
                    osym_next  = '0;
                    state_next = S_RESP;
                end
                else if (!last_step)
                begin
                    if (child == '0)
                    begin
                        need_next  = len_reg - LEN_W'(idx_reg);
                        state_next = S_FULL;
                    end
                    else
                    begin
                        cur_next   = child;
                        idx_next   = idx_reg + LW'(1);
                        fetch_en   = 1'b1;
                        fetch_addr = child;
                    end
                end
                else if (child != '0)
                begin
                    st_next    = ST_CONFLICT;
                    osym_next  = '0;
                    state_next = S_RESP;
                end
                else
                begin
                    need_next  = LEN_W'(1);
                    state_next = S_FULL;
                end
            end

            // room check for the new nodes
            S_FULL:
            begin
                if (fill_sum > SW'(NODE_CAP))
                begin
                    st_next    = ST_FULL;
                    osym_next  = '0;
                    state_next = S_RESP;
                end
                else
                begin
                    cur_next   = '0;
                    idx_next   = '0;
                    fetch_en   = 1'b1;
                    fetch_addr = '0;
                    state_next = S_CMT;
                end
            end

            // commit walk, creating nodes as needed
            S_CMT:
            begin
                if (!last_step && child != '0)
                begin
                    cur_next   = child;
                    idx_next   = idx_reg + LW'(1);
                    fetch_en   = 1'b1;
                    fetch_addr = child;
                end
                else
                begin
                    wr_cur  = 1'b1;
                    wr_node = set_link(ent, code_b, nodes_used_reg[NW-1:0]);
                    if (!last_step)
                    begin
                        // fresh internal node reads empty next cycle
                        cur_next        = nodes_used_reg[NW-1:0];
                        nodes_used_next = nodes_used_reg + CW'(1);
                        idx_next        = idx_reg + LW'(1);
                    end
                    else
                    begin
                        state_next = S_LEAF;
                    end
                end
            end

            // write the new leaf
            S_LEAF:
            begin
                ram_we          = 1'b1;
                ram_waddr       = nodes_used_reg[NW-1:0];
                ram_wdata       = EW'({sym_reg, 1'b1, {(2 * NW){1'b0}}});
                nodes_used_next = nodes_used_reg + CW'(1);
                state_next      = S_IDLE;
            end

            // decode: follow one branch
            S_DSTEP:
            begin
                if (child == '0)
                begin
                    current_node_next = '0;
                    st_next           = ST_MISSING;
                    osym_next         = '0;
                    state_next        = S_RESP;
                end
                else
                begin
                    cur_next   = child;
                    fetch_en   = 1'b1;
                    fetch_addr = child;
                    state_next = S_DLEAF;
                end
            end

            // decode: leaf test on the reached node
            S_DLEAF:
            begin
                if (ent.leaf)
                begin
                    current_node_next = '0;
                    st_next           = ST_OK;
                    osym_next         = ent.sym;
                    state_next        = S_RESP;
                end
                else
                begin
                    current_node_next = cur_reg;
                    state_next        = S_IDLE;
                end
            end

            // hand the result to the output register
            S_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = STATUS_W'(st_reg);
                    m_tdata_next  = OUT_DATA_W'(osym_reg);
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // node write-back: root in flops, others in ram
        if (wr_cur)
        begin
            if (cur_reg == '0)
            begin
                root_left_next  = wr_node.left;
                root_right_next = wr_node.right;
            end
            else
            begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg;
                ram_wdata = EW'(wr_node);
            end
        end

        // read issue and entry source for the next cycle
        ram_raddr        = fetch_addr;
        fetch_root_next  = fetch_en && (fetch_addr == '0);
        fetch_valid_next = fetch_en && (fetch_addr != '0) &&
                           (CW'(fetch_addr) < nodes_used_reg);
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            root_left_reg    <= '0;
            root_right_reg   <= '0;
            nodes_used_reg   <= CW'(1);
            current_node_reg <= '0;
            cur_reg          <= '0;
            idx_reg          <= '0;
            need_reg         <= '0;
            sym_reg          <= '0;
            len_reg          <= '0;
            code_reg         <= '0;
            bit_reg          <= 1'b0;
            fetch_root_reg   <= 1'b0;
            fetch_valid_reg  <= 1'b0;
            st_reg           <= ST_OK;
            osym_reg         <= '0;
            m_tvalid_reg     <= 1'b0;
            m_tuser_reg      <= '0;
            m_tdata_reg      <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            root_left_reg    <= root_left_next;
            root_right_reg   <= root_right_next;
            nodes_used_reg   <= nodes_used_next;
            current_node_reg <= current_node_next;
            cur_reg          <= cur_next;
            idx_reg          <= idx_next;
            need_reg         <= need_next;
            sym_reg          <= sym_next;
            len_reg          <= len_next;
            code_reg         <= code_next;
            bit_reg          <= bit_next;
            fetch_root_reg   <= fetch_root_next;
            fetch_valid_reg  <= fetch_valid_next;
            st_reg           <= st_next;
            osym_reg         <= osym_next;
            m_tvalid_reg     <= m_tvalid_next;
            m_tuser_reg      <= m_tuser_next;
            m_tdata_reg      <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    `HTD_ASSERT_IMPL(a_fill_cap, clk, rst_n, 1'b1, nodes_used_reg <= CW'(NODE_CAP),
                     "fill count past node store")
    `HTD_ASSERT_IMPL(a_wr_alloc, clk, rst_n, ram_we, CW'(ram_waddr) <= nodes_used_reg,
                     "write beyond allocated nodes")
    `HTD_ASSERT_IMPL(a_cur_alloc, clk, rst_n, 1'b1, CW'(current_node_reg) < nodes_used_reg,
                     "current node not allocated")
    `HTD_ASSERT_NEXT(a_clear, clk, rst_n, s_tvalid && s_tready && s_tuser == FN_CLEAR,
                     nodes_used_reg == CW'(1) && current_node_reg == '0,
                     "clear did not empty tree")
    `HTD_ASSERT_IMPL(a_resp_src, clk, rst_n, $rose(m_tvalid_reg),
                     $past(state_reg == S_RESP), "result not from response state")

endmodule

`default_nettype wire

### verif/huffman_tree_decoder_checker.sv
// checker for the huffman tree decoder: follows both stream channels, keeps its own
// copy of the code tree and matches every output transfer against the predicted result
// depends on htd_pkg for field widths, operation codes and status codes
module huffman_tree_decoder_checker
    import htd_pkg::*;
#(
    parameter int MAX_SYMBOLS  = DEF_MAX_SYMBOLS,
    parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [FUNC_W-1:0]     s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic [STATUS_W-1:0]   m_tuser,
    output int                    mismatches,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODE_DEPTH = 512;
    localparam int NODE_CAP   = 2 * MAX_SYMBOLS;

    typedef struct packed {
        status_t          status;
        logic [SYM_W-1:0] symbol;
    } decode_result_t;

    // predicted results, oldest first
    decode_result_t result_q[$];

    // shadow code tree
    logic [8:0]       left_node  [NODE_DEPTH];
    logic [8:0]       right_node [NODE_DEPTH];
    bit               leaf_flag  [NODE_DEPTH];
    logic [SYM_W-1:0] leaf_byte  [NODE_DEPTH];
    logic [9:0]       fill_count;
    logic [8:0]       walk_node;

    int             fail_total = 0;
    decode_result_t want;
    decode_result_t got;
    logic [8:0]     next_node;
    status_t        load_status;

    assign mismatches = fail_total;

    function automatic void empty_tree();
        for (int i = 0; i < NODE_DEPTH; i++)
        begin
            left_node[i]  = '0;
            right_node[i] = '0;
            leaf_flag[i]  = 1'b0;
            leaf_byte[i]  = '0;
        end
        fill_count = 10'd1;
        walk_node  = '0;
    endfunction

    function automatic logic [8:0] branch(input logic [8:0] node, input logic dir);
        return dir ? right_node[node] : left_node[node];
    endfunction

    function automatic void set_branch(input logic [8:0] node, input logic dir,
                                       input logic [8:0] child);
        if (dir)
            right_node[node] = child;
        else
            left_node[node] = child;
    endfunction

    // insert one symbol; the whole path is checked before the tree is touched
    function automatic status_t insert_code(input logic [SYM_W-1:0] sym, input int len,
                                            input logic [CODE_W-1:0] path);
        logic [8:0] node;
        logic [8:0] child;
        int         need;
        bit         fresh;

        if (len == 0 || len > MAX_CODE_LEN)
            return ST_BADLEN;
        node  = '0;
        need  = 1;
        fresh = 1'b0;
        for (int i = 0; i + 1 < len; i++)
        begin
            if (!fresh)
            begin
                if (leaf_flag[node])
                    return ST_CONFLICT;
                child = branch(node, path[i]);
                if (child == '0)
                begin
                    fresh = 1'b1;
                    need++;
                end
                else
                    node = child;
            end
            else
                need++;
        end
        if (!fresh)
        begin
            if (leaf_flag[node])
                return ST_CONFLICT;
            if (branch(node, path[len-1]) != '0)
                return ST_CONFLICT;
        end
        if (int'(fill_count) > NODE_CAP || need > NODE_CAP - int'(fill_count))
            return ST_FULL;

        // commit the path, then hang the leaf at the end
        node = '0;
        for (int i = 0; i + 1 < len; i++)
        begin
            child = branch(node, path[i]);
            if (child == '0)
            begin
                child = fill_count[8:0];
                fill_count++;
                set_branch(node, path[i], child);
            end
            node = child;
        end
        child = fill_count[8:0];
        fill_count++;
        leaf_flag[child] = 1'b1;
        leaf_byte[child] = sym;
        set_branch(node, path[len-1], child);
        return ST_OK;
    endfunction

    function automatic void note_failure(input string what);
        if (fail_total < 10)
            $display("%0t: %s", $time, what);
        fail_total++;
    endfunction

    // follow both channels; input side first so the order of expectations is kept
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_tree();
            result_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                case (s_tuser)
                    FN_LOAD:
                    begin
                        load_status = insert_code(s_tdata[7:0], int'(s_tdata[15:8]),
                                                  s_tdata[47:16]);
                        if (load_status != ST_OK)
                            result_q.push_back('{status: load_status, symbol: '0});
                    end
                    FN_DECODE:
                    begin
                        next_node = branch(walk_node, s_tdata[48]);
                        if (next_node == '0)
                        begin
                            walk_node = '0;
                            result_q.push_back('{status: ST_MISSING, symbol: '0});
                        end
                        else if (leaf_flag[next_node])
                        begin
                            walk_node = '0;
                            result_q.push_back('{status: ST_OK,
                                                 symbol: leaf_byte[next_node]});
                        end
                        else
                            walk_node = next_node;
                    end
                    FN_CLEAR:
                        empty_tree();
                    default:
                        ;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                got = '{status: status_t'(m_tuser), symbol: m_tdata};
                if (result_q.size() == 0)
                    note_failure($sformatf("result with none pending: status %0d symbol %02h",
                                           m_tuser, m_tdata));
                else
                begin
                    want = result_q.pop_front();
                    if (want.status !== got.status || want.symbol !== got.symbol)
                        note_failure($sformatf(
                            "mismatch: status exp %0d got %0d, symbol exp %02h got %02h",
                            want.status, m_tuser, want.symbol, m_tdata));
                end
            end
            outstanding <= result_q.size();
        end
    end

endmodule

### verif/huffman_tree_decoder_tb.sv
// testbench top for the huffman tree decoder: builds random prefix codes, loads them,
// streams coded bits with random gaps and stalls and gives the verdict
// depends on htd_pkg, huffman_tree_decoder and huffman_tree_decoder_checker
module huffman_tree_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import htd_pkg::*;

    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
    localparam int ITEM_TARGET  = 1250;
    localparam int DRAIN_CYCLES = 100;
    localparam int TIMEOUT_NS   = 10_000_000;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [FUNC_W-1:0]     s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    int mismatches;
    int outstanding;
    int items_sent = 0;
    int idle_pct   = 0;
    int stall_pct  = 0;

    // current prefix code: path bits, lengths and symbols
    logic [CODE_W-1:0] tree_code[$];
    int                tree_len[$];
    logic [SYM_W-1:0]  tree_sym[$];
    int                load_order[$];

    huffman_tree_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    huffman_tree_decoder_checker tree_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver back-pressure
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    initial
    begin
        #(TIMEOUT_NS);
        $display("huffman_tree_decoder_tb failed");
        $finish;
    end

    // one input transfer, with random idle cycles in front of it
    task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [SYM_W-1:0] sym,
                             input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] path,
                             input logic dir);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {7'd0, dir, path, len, sym};
        do
            @(posedge clk);
        while (!s_tready);
        if (fn != FN_UNUSED)
            items_sent++;
    endtask

    // bits above the code length are don't-care and get random values
    task automatic load_code(input logic [SYM_W-1:0] sym, input int len,
                             input logic [CODE_W-1:0] path);
        logic [CODE_W-1:0] mask;

        mask = (len >= CODE_W) ? '1 : CODE_W'((64'd1 << len) - 1);
        send_item(FN_LOAD, sym, LEN_W'(len), (path & mask) | ($urandom & ~mask),
                  1'($urandom_range(1)));
    endtask

    task automatic decode_bit(input logic dir);
        send_item(FN_DECODE, SYM_W'($urandom), LEN_W'($urandom), $urandom, dir);
    endtask

    task automatic other_item(input logic [FUNC_W-1:0] fn);
        send_item(fn, SYM_W'($urandom), LEN_W'($urandom), $urandom, 1'($urandom_range(1)));
    endtask

    // grow a complete prefix code by splitting leaves; chain splits the newest leaf
    task automatic build_code(input int nleaves, input int maxlen, input bit chain);
        int   k;
        int   tries;
        logic dir;

        tree_code.delete();
        tree_len.delete();
        tree_sym.delete();
        tree_code.push_back('0);
        tree_code.push_back(32'd1);
        tree_len.push_back(1);
        tree_len.push_back(1);
        tries = 0;
        while (tree_code.size() < nleaves && tries < 4 * nleaves + 16)
        begin
            tries++;
            k = chain ? tree_code.size() - 1 : $urandom_range(tree_code.size() - 1);
            if (tree_len[k] < maxlen)
            begin
                dir = 1'($urandom_range(1));
                tree_code.push_back(tree_code[k] | (CODE_W'(dir) << tree_len[k]));
                tree_code[k] = tree_code[k] | (CODE_W'(!dir) << tree_len[k]);
                tree_len[k]  = tree_len[k] + 1;
                tree_len.push_back(tree_len[k]);
            end
        end
        foreach (tree_code[i])
            tree_sym.push_back(SYM_W'($urandom));
    endtask

    initial
    begin
        int  round;
        int  kind;
        int  n;
        int  k;
        int  tmp;
        int  skip;
        bit  chain;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty tree, bad lengths, conflicts, extreme codes
        decode_bit(1'b1);
        load_code(8'h11, 0, '0);
        load_code(8'h22, 33, '1);
        load_code(8'hFF, 255, '1);
        load_code(8'hA5, 1, '0);
        load_code(8'h5A, 1, '0);
        load_code(8'h3C, 2, '0);
        load_code(8'hFF, 32, 32'hFFFF_FFFF);
        load_code(8'h00, 3, 32'b011);
        load_code(8'h77, 1, 32'b1);
        load_code(8'h66, 2, 32'b11);
        decode_bit(1'b0);
        decode_bit(1'b1);
        decode_bit(1'b1);
        decode_bit(1'b0);
        decode_bit(1'b1);
        decode_bit(1'b0);
        other_item(FN_UNUSED);
        decode_bit(1'b1);
        other_item(FN_CLEAR);
        decode_bit(1'b0);
        load_code(8'h80, 32, '0);

        round = 0;
        while (items_sent < ITEM_TARGET)
        begin
            // rotate through idle and stall phases
            case (round % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 75; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 75; end
                default: begin idle_pct = 14; stall_pct = 14; end
            endcase
            round++;
            kind = $urandom_range(9);

            if (kind < 7)
            begin
                // well-formed round: load a full code, sometimes less one entry, then decode symbols from it
                other_item(FN_CLEAR);
                chain = ($urandom_range(7) == 0);
                if (chain)
                    build_code(32, 32, 1'b1);
                else
                    build_code($urandom_range(2, 20), $urandom_range(2, 10), 1'b0);
                load_order.delete();
                foreach (tree_code[i])
                    load_order.push_back(i);
                for (int j = load_order.size() - 1; j > 0; j--)
                begin
                    k = $urandom_range(j);
                    tmp = load_order[j];
                    load_order[j] = load_order[k];
                    load_order[k] = tmp;
                end
                skip = ($urandom_range(7) == 0) ? $urandom_range(tree_code.size() - 1) : -1;
                foreach (load_order[j])
                    if (load_order[j] != skip)
                        load_code(tree_sym[load_order[j]], tree_len[load_order[j]],
                                  tree_code[load_order[j]]);
                // repeated entry or one that runs through an existing leaf
                if ($urandom_range(3) == 0)
                begin
                    k = $urandom_range(tree_code.size() - 1);
                    if ($urandom_range(1))
                        load_code(SYM_W'($urandom), tree_len[k], tree_code[k]);
                    else
                        load_code(SYM_W'($urandom), tree_len[k] + 1,
                                  tree_code[k] | (CODE_W'($urandom_range(1)) << tree_len[k]));
                end
                n = chain ? $urandom_range(6, 12) : $urandom_range(10, 40);
                repeat (n)
                begin
                    if ($urandom_range(15) == 0)
                        decode_bit(1'($urandom_range(1)));
                    k = $urandom_range(tree_code.size() - 1);
                    for (int j = 0; j < tree_len[k]; j++)
                        decode_bit(tree_code[k][j]);
                end
            end
            else if (kind == 7)
            begin
                // fill the node store with long random codes until it overflows
                other_item(FN_CLEAR);
                repeat (24)
                    load_code(SYM_W'($urandom), $urandom_range(28, 32), $urandom);
                repeat (3)
                    load_code(SYM_W'($urandom), $urandom_range(1, 4), $urandom);
                repeat (30)
                    decode_bit(1'($urandom_range(1)));
            end
            else
            begin
                // noise on top of whatever tree is left
                repeat (20)
                begin
                    n = $urandom_range(9);
                    if (n < 4)
                        load_code(SYM_W'($urandom),
                                  $urandom_range(1) ? $urandom_range(255) : $urandom_range(1, 8),
                                  $urandom);
                    else if (n < 8)
                        decode_bit(1'($urandom_range(1)));
                    else if (n == 8)
                        other_item(FN_CLEAR);
                    else
                        other_item(FN_UNUSED);
                end
            end
        end

        // let a load finish walking the tree, then wait for every predicted result
        s_tvalid <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        if (mismatches == 0)
            $display("huffman_tree_decoder_tb passed");
        else
            $display("huffman_tree_decoder_tb failed");
        $finish;
    end

endmodule
